>>> src/ifrr_pkg.sv
`default_nettype none

package ifrr_pkg;

  // Opcodes of an input item
  localparam logic [1:0] OP_BYTE = 2'd0;
  localparam logic [1:0] OP_IDLE = 2'd1;
  localparam logic [1:0] OP_READ = 2'd2;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] rx_byte;
    logic [7:0] read_index;
  } in_item_t;

  typedef struct packed {
    logic       frame_valid;
    logic [7:0] frame_start;
    logic [7:0] frame_end;
    logic [8:0] frame_length;
    logic       overflow;
    logic       read_valid;
    logic [7:0] read_data;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;    // beat accepted: update pointers, stage result
    logic load_read;  // RAM data is back: place it in the result
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_read;
  } stat_t;

endpackage

`default_nettype wire

>>> src/ifrr_ram.sv
`default_nettype none

module ifrr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> src/ifrr_ctrl.sv
`default_nettype none

module ifrr_ctrl import ifrr_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  wire logic  out_ready,
  input  wire stat_t stat,
  output cmd_t       cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_RESP
  } state_t;

  state_t state_r;
  state_t state_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_RESP);

  always_comb begin
    state_nxt         = state_r;
    cmd.capture       = 1'b0;
    cmd.load_read     = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = stat.is_read ? S_READ : S_RESP;
        end
      end
      S_READ: begin
        cmd.load_read = 1'b1;
        state_nxt     = S_RESP;
      end
      S_RESP: begin
        if (out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

>>> src/ifrr_dp.sv
`default_nettype none

module ifrr_dp import ifrr_pkg::*; #(
  parameter int BUFFER_DEPTH = 256
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire in_item_t in_data,
  input  wire cmd_t     cmd,
  output stat_t         stat,
  output out_item_t     out_data
);

  localparam int PW = $clog2(BUFFER_DEPTH);
  localparam int CW = $clog2(BUFFER_DEPTH + 1);
  localparam int LW = PW + 1;
  localparam int RW = PW + 9;
  localparam int SH = PW + 8;
  localparam int PRW = SH + 9;
  localparam logic [PW-1:0] LAST_PTR = PW'(BUFFER_DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(BUFFER_DEPTH);
  localparam logic [LW-1:0] DEPTH_L  = LW'(BUFFER_DEPTH);
  localparam logic [RW-1:0] DEPTH_R  = RW'(BUFFER_DEPTH);
  localparam logic [SH:0]   RECIP    = (SH + 1)'(((1 << SH) + BUFFER_DEPTH - 1) / BUFFER_DEPTH);

  logic [PW-1:0] wp_r, wp_nxt;
  logic [PW-1:0] fs_r, fs_nxt;
  logic [CW-1:0] pend_r, pend_nxt;
  out_item_t     out_r, out_nxt;

  logic [PW-1:0]  wp_inc;
  logic [LW-1:0]  len;
  logic [PRW-1:0] rd_prod;
  logic [7:0]     rd_quo;
  logic [RW-1:0]  rd_rem;
  logic [PW-1:0]  rd_addr;
  logic [7:0]     ram_rdata;
  logic           is_byte;
  logic           is_idle;

  assign stat.is_read = (in_data.opcode == OP_READ);
  assign is_byte      = (in_data.opcode == OP_BYTE);
  assign is_idle      = (in_data.opcode == OP_IDLE);
  assign out_data     = out_r;

  assign wp_inc = (wp_r == LAST_PTR) ? '0 : wp_r + PW'(1);

  // Frame length, modulo depth; a saturated count reports the full depth
  always_comb begin
    if (pend_r == FULL_CNT) begin
      len = DEPTH_L;
    end else if (wp_r >= fs_r) begin
      len = LW'(wp_r) - LW'(fs_r);
    end else begin
      len = LW'(wp_r) + DEPTH_L - LW'(fs_r);
    end
  end

  // Reduce the read index modulo depth: quotient by reciprocal multiply,
  // exact for every 8-bit index, then subtract quotient times depth
  assign rd_prod = PRW'(in_data.read_index) * PRW'(RECIP);
  assign rd_quo  = rd_prod[SH+7:SH];
  assign rd_rem  = RW'(in_data.read_index) - RW'(rd_quo) * DEPTH_R;
  assign rd_addr = rd_rem[PW-1:0];

  ifrr_ram #(
    .WIDTH(8),
    .DEPTH(BUFFER_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (cmd.capture && is_byte),
    .waddr(wp_r),
    .wdata(in_data.rx_byte),
    .re   (cmd.capture && stat.is_read),
    .raddr(rd_addr),
    .rdata(ram_rdata)
  );

  always_comb begin
    wp_nxt   = wp_r;
    fs_nxt   = fs_r;
    pend_nxt = pend_r;
    out_nxt  = out_r;
    if (cmd.capture) begin
      out_nxt = '0;
      if (is_byte) begin
        wp_nxt           = wp_inc;
        pend_nxt         = (pend_r == FULL_CNT) ? pend_r : pend_r + CW'(1);
        out_nxt.overflow = (wp_inc == fs_r);
      end else if (is_idle) begin
        out_nxt.frame_valid  = 1'b1;
        out_nxt.frame_start  = 8'(fs_r);
        out_nxt.frame_end    = 8'(wp_r);
        out_nxt.frame_length = 9'(len);
        fs_nxt               = wp_r;
        pend_nxt             = '0;
      end
    end else if (cmd.load_read) begin
      out_nxt.read_valid = 1'b1;
      out_nxt.read_data  = ram_rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r   <= '0;
      fs_r   <= '0;
      pend_r <= '0;
    end else begin
      wp_r   <= wp_nxt;
      fs_r   <= fs_nxt;
      pend_r <= pend_nxt;
    end
    out_r <= out_nxt;
  end

endmodule

`default_nettype wire

>>> src/idle_framed_receive_ring_unit.sv
`default_nettype none

// Channel   Dir  Handshake            Beat
// in        in   in_valid/in_ready    in_item_t  (opcode, rx_byte, read_index)
// out       out  out_valid/out_ready  out_item_t (frame and read fields)
//
// One item is in flight at a time. A byte or idle beat gives its result in the
// cycle after acceptance; a read beat waits in S_READ for the registered RAM
// read port first. in_ready returns the cycle after the result beat is taken,
// so no new item is accepted before the last result, stalled or not, is taken.
// Reset (rst_n low, synchronous) clears the pointers and the byte count; the
// byte store is not cleared and no clearing pass runs.
module idle_framed_receive_ring_unit import ifrr_pkg::*; #(
  parameter int BUFFER_DEPTH = 256
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire in_item_t in_data,
  output logic          out_valid,
  input  wire logic     out_ready,
  output out_item_t     out_data
);

  cmd_t  cmd;
  stat_t stat;

  // Sequence each beat: accept, wait on the RAM for reads, hold the result
  ifrr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Pointers, byte count, byte store and the result register
  ifrr_dp #(
    .BUFFER_DEPTH(BUFFER_DEPTH)
  ) u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_data (in_data),
    .cmd     (cmd),
    .stat    (stat),
    .out_data(out_data)
  );

`ifndef SYNTHESIS
  // Never take a new beat while a result is still held
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input accepted while a result is pending");

  // Byte and idle beats answer on the next cycle
  a_fast_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_data.opcode != OP_READ) |=> out_valid)
    else $error("byte or idle result late");

  // A read answer carries no frame or overflow flags
  a_read_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.read_valid) |->
      (!out_data.frame_valid && !out_data.overflow))
    else $error("read result mixed with frame flags");

  // Reads hold off the result for the RAM latency
  a_read_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_data.opcode == OP_READ) |=> !out_valid ##1 out_valid)
    else $error("read result timing wrong");
`endif

endmodule

`default_nettype wire
